@@ src/rv32im_register_alu_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the register ALU
// Concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef RV32IM_REGISTER_ALU_TOP_MACROS_SVH
`define RV32IM_REGISTER_ALU_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/rv32_alu_pkg.sv @@
// ----------------------------------------------------------------------------
// Register ALU package
// Operation codes, pipeline sizes and the per-stage item record.
// ----------------------------------------------------------------------------
package rv32_alu_pkg;
    localparam int XLEN   = 32;
    localparam int OPW    = 5;
    // divider retires this many quotient bits per stage
    localparam int DBITS  = 4;
    localparam int DSTAGES = XLEN / DBITS;
    // whole pipeline: operand prep, DSTAGES divide steps, finish
    localparam int NSTAGES = DSTAGES + 2;

    localparam logic [OPW-1:0] OP_ADD    = 5'd0;
    localparam logic [OPW-1:0] OP_SUB    = 5'd1;
    localparam logic [OPW-1:0] OP_SLL    = 5'd2;
    localparam logic [OPW-1:0] OP_SLT    = 5'd3;
    localparam logic [OPW-1:0] OP_SLTU   = 5'd4;
    localparam logic [OPW-1:0] OP_XOR    = 5'd5;
    localparam logic [OPW-1:0] OP_SRL    = 5'd6;
    localparam logic [OPW-1:0] OP_SRA    = 5'd7;
    localparam logic [OPW-1:0] OP_OR     = 5'd8;
    localparam logic [OPW-1:0] OP_AND    = 5'd9;
    localparam logic [OPW-1:0] OP_MUL    = 5'd10;
    localparam logic [OPW-1:0] OP_MULH   = 5'd11;
    localparam logic [OPW-1:0] OP_MULHSU = 5'd12;
    localparam logic [OPW-1:0] OP_MULHU  = 5'd13;
    localparam logic [OPW-1:0] OP_DIV    = 5'd14;
    localparam logic [OPW-1:0] OP_DIVU   = 5'd15;
    localparam logic [OPW-1:0] OP_REM    = 5'd16;
    localparam logic [OPW-1:0] OP_REMU   = 5'd17;

    // item travelling through the divider stages
    typedef struct packed {
        logic [OPW-1:0]  op;
        logic [XLEN-1:0] early;   // result of non-divide ALU or multiply ops
        logic [XLEN-1:0] quo;     // quotient bits / dividend shift
        logic [XLEN:0]   rem;     // partial remainder
        logic [XLEN-1:0] dsr;     // divisor magnitude
        logic            neg_q;
        logic            neg_r;
        logic            dz;      // divide by zero
        logic [XLEN-1:0] a;
    } t_item;
endpackage

@@ src/rv32_alu_front.sv @@
// ----------------------------------------------------------------------------
// Register ALU front stage
// Computes the non-divide ALU results, multiplies, and divider operand prep.
// ----------------------------------------------------------------------------
module rv32_alu_front
    import rv32_alu_pkg::*;
(
    input  logic [OPW-1:0]  i_op,
    input  logic [XLEN-1:0] i_a,
    input  logic [XLEN-1:0] i_b,
    output t_item           o_item
);
    logic [4:0]          sh;
    logic [XLEN-1:0]     r;
    logic signed [XLEN:0] ma;
    logic signed [XLEN:0] mb;
    logic signed [2*XLEN+1:0] prod;
    logic                sgn_div;
    logic [XLEN-1:0]     mag_a;
    logic [XLEN-1:0]     mag_b;

    // multiplier operands: extend by sign where the op is signed
    always_comb begin
        ma = {((i_op == OP_MULH) || (i_op == OP_MULHSU)) & i_a[XLEN-1], i_a};
        mb = {(i_op == OP_MULH) & i_b[XLEN-1], i_b};
        prod = ma * mb;
    end

    // pick the non-divide result
    always_comb begin
        sh = i_b[4:0];
        case (i_op)
            OP_ADD:    r = i_a + i_b;
            OP_SUB:    r = i_a - i_b;
            OP_SLL:    r = i_a << sh;
            OP_SLT:    r = {31'd0, $signed(i_a) < $signed(i_b)};
            OP_SLTU:   r = {31'd0, i_a < i_b};
            OP_XOR:    r = i_a ^ i_b;
            OP_SRL:    r = i_a >> sh;
            OP_SRA:    r = XLEN'($signed(i_a) >>> sh);
            OP_OR:     r = i_a | i_b;
            OP_AND:    r = i_a & i_b;
            OP_MUL:    r = prod[XLEN-1:0];
            OP_MULH, OP_MULHSU, OP_MULHU: r = prod[2*XLEN-1:XLEN];
            default:   r = '0;
        endcase
    end

    // divider operands as magnitudes
    always_comb begin
        sgn_div = (i_op == OP_DIV) || (i_op == OP_REM);
        mag_a   = (sgn_div && i_a[XLEN-1]) ? (XLEN'(0) - i_a) : i_a;
        mag_b   = (sgn_div && i_b[XLEN-1]) ? (XLEN'(0) - i_b) : i_b;
        o_item.op    = i_op;
        o_item.early = r;
        o_item.quo   = mag_a;
        o_item.rem   = '0;
        o_item.dsr   = mag_b;
        o_item.neg_q = sgn_div && (i_a[XLEN-1] ^ i_b[XLEN-1]);
        o_item.neg_r = sgn_div && i_a[XLEN-1];
        o_item.dz    = (i_b == '0);
        o_item.a     = i_a;
    end
endmodule

@@ src/rv32_alu_divstep.sv @@
// ----------------------------------------------------------------------------
// Register ALU divide step
// Retires DBITS quotient bits by restoring division.
// ----------------------------------------------------------------------------
module rv32_alu_divstep
    import rv32_alu_pkg::*;
(
    input  t_item i_item,
    output t_item o_item
);
    logic [XLEN:0]   rm;
    logic [XLEN-1:0] q;
    logic [XLEN:0]   diff;

    // shift one dividend bit into the remainder, subtract if it fits
    always_comb begin
        o_item = i_item;
        rm = i_item.rem;
        q  = i_item.quo;
        for (int k = 0; k < DBITS; k++) begin
            rm   = {rm[XLEN-1:0], q[XLEN-1]};
            q    = {q[XLEN-2:0], 1'b0};
            diff = rm - {1'b0, i_item.dsr};
            if (!diff[XLEN]) begin
                rm   = diff;
                q[0] = 1'b1;
            end
        end
        o_item.rem = rm;
        o_item.quo = q;
    end
endmodule

@@ src/rv32_alu_back.sv @@
// ----------------------------------------------------------------------------
// Register ALU back stage
// Applies signs and the divide-by-zero rules and selects the result.
// ----------------------------------------------------------------------------
module rv32_alu_back
    import rv32_alu_pkg::*;
(
    input  t_item           i_item,
    output logic [XLEN-1:0] o_result
);
    logic [XLEN-1:0] q;
    logic [XLEN-1:0] rm;

    // fix signs, then divide-by-zero overrides
    always_comb begin
        q  = i_item.neg_q ? (XLEN'(0) - i_item.quo) : i_item.quo;
        rm = i_item.neg_r ? (XLEN'(0) - i_item.rem[XLEN-1:0]) : i_item.rem[XLEN-1:0];
        case (i_item.op)
            OP_DIV, OP_DIVU: o_result = i_item.dz ? '1 : q;
            OP_REM, OP_REMU: o_result = i_item.dz ? i_item.a : rm;
            default:         o_result = i_item.early;
        endcase
    end
endmodule

@@ src/rv32im_register_alu_top.sv @@
// Every op, divide or not, passes through all the stages from input beat to output beat.
// Throughput: one beat per cycle unless stalled; the 4-bit-per-stage divide sets depth.
// A stall holds the output and every stage down to the nearest bubble; the input
// is taken while the output register waits if any stage is empty. Reset clears all valid bits.
// ----------------------------------------------------------------------------
// Register ALU top level
// RV32IM register-register execute unit, fully pipelined.
// ----------------------------------------------------------------------------
`include "rv32im_register_alu_top_macros.svh"
module rv32im_register_alu_top
    import rv32_alu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // op[4:0], first_operand[36:5], second_operand[68:37]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // result[31:0]
);
    t_item           r_stage [NSTAGES-1];
    logic [NSTAGES-1:0] r_vld;
    t_item           front_item;
    t_item           step_out [DSTAGES];
    logic [XLEN-1:0] back_res;
    logic [XLEN-1:0] r_res;
    logic            advance;

    // pipeline moves when the output is free or any slot is a bubble
    assign advance       = !r_vld[NSTAGES-1] || m_axis_tready || !(&r_vld[NSTAGES-2:0]);
    assign s_axis_tready = advance;
    assign m_axis_tvalid = r_vld[NSTAGES-1];
    assign m_axis_tdata  = r_res;

    rv32_alu_front u_front (
        .i_op   (s_axis_tdata[4:0]),
        .i_a    (s_axis_tdata[36:5]),
        .i_b    (s_axis_tdata[68:37]),
        .o_item (front_item)
    );

    genvar g;
    generate
        for (g = 0; g < DSTAGES; g++) begin : g_div
            rv32_alu_divstep u_step (.i_item(r_stage[g]), .o_item(step_out[g]));
        end
    endgenerate

    rv32_alu_back u_back (.i_item(r_stage[NSTAGES-2]), .o_result(back_res));

    // advance stages; a bubble lets the stages behind it close up
    always_ff @(posedge i_clk) begin
        logic go;
        go = (!r_vld[NSTAGES-1]) || m_axis_tready;
        if (go) begin
            r_res <= back_res;
        end
        for (int k = NSTAGES-2; k >= 1; k--) begin
            go = go || !r_vld[k];
            if (go) begin
                r_stage[k] <= step_out[k-1];
            end
        end
        go = go || !r_vld[0];
        if (go) begin
            r_stage[0] <= front_item;
        end
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            go = (!r_vld[NSTAGES-1]) || m_axis_tready;
            if (go) begin
                r_vld[NSTAGES-1] <= r_vld[NSTAGES-2];
            end
            for (int k = NSTAGES-2; k >= 1; k--) begin
                go = go || !r_vld[k];
                if (go) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            go = go || !r_vld[0];
            if (go) begin
                r_vld[0] <= s_axis_tvalid;
            end
        end
    end

    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !r_vld[NSTAGES-1], s_axis_tready)
endmodule
